// ----- rtl/core/ecpb_pkg.sv -----
`default_nettype none

package ecpb_pkg;

  // Configuration register indexes on the write port.
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_EVENT_TARGET   = 3'd0,
    CFG_PULSE_COUNT    = 3'd1,
    CFG_DEBOUNCE_TICKS = 3'd2,
    CFG_ON_TICKS       = 3'd3,
    CFG_OFF_TICKS      = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned PulseW   = 4;
  localparam int unsigned TimerW   = 16;

  // Values after reset.
  localparam logic [CountW-1:0] EventTargetRst   = 8'd10;
  localparam logic [PulseW-1:0] PulseCountRst    = 4'd4;
  localparam logic [TimerW-1:0] DebounceTicksRst = 16'd50;
  localparam logic [TimerW-1:0] OnTicksRst       = 16'd10000;
  localparam logic [TimerW-1:0] OffTicksRst      = 16'd15000;

  typedef struct packed {
    logic [CountW-1:0] event_target;
    logic [PulseW-1:0] pulse_count;
    logic [TimerW-1:0] debounce_ticks;
    logic [TimerW-1:0] on_ticks;
    logic [TimerW-1:0] off_ticks;
  } cfg_t;

  typedef struct packed {
    logic              drive_out;
    logic              led_out;
    logic              cpu_signal;
    logic [CountW-1:0] events_so_far;
  } res_t;

  // Sequencer phases, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_ON   = 4'b0100,
    PH_OFF  = 4'b1000
  } phase_e;

endpackage

`default_nettype wire

// ----- rtl/core/ecpb_cfg.sv -----
`default_nettype none

module ecpb_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ecpb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ecpb_pkg::CfgDataW-1:0]  cfg_data_i,
  output ecpb_pkg::cfg_t                      cfg_o
);

  ecpb_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ecpb_pkg::CFG_EVENT_TARGET:
          cfg_d.event_target = cfg_data_i[ecpb_pkg::CountW-1:0];
        ecpb_pkg::CFG_PULSE_COUNT:
          cfg_d.pulse_count = cfg_data_i[ecpb_pkg::PulseW-1:0];
        ecpb_pkg::CFG_DEBOUNCE_TICKS:
          cfg_d.debounce_ticks = cfg_data_i[ecpb_pkg::TimerW-1:0];
        ecpb_pkg::CFG_ON_TICKS:
          cfg_d.on_ticks = cfg_data_i[ecpb_pkg::TimerW-1:0];
        ecpb_pkg::CFG_OFF_TICKS:
          cfg_d.off_ticks = cfg_data_i[ecpb_pkg::TimerW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.event_target   <= ecpb_pkg::EventTargetRst;
      cfg_q.pulse_count    <= ecpb_pkg::PulseCountRst;
      cfg_q.debounce_ticks <= ecpb_pkg::DebounceTicksRst;
      cfg_q.on_ticks       <= ecpb_pkg::OnTicksRst;
      cfg_q.off_ticks      <= ecpb_pkg::OffTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/ecpb_seq.sv -----
`default_nettype none

module ecpb_seq (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire logic  pin_a_i,
  input  wire logic  pin_b_i,
  input  wire ecpb_pkg::cfg_t cfg_i,
  output ecpb_pkg::res_t res_o
);

  localparam int unsigned CountW = ecpb_pkg::CountW;
  localparam int unsigned PulseW = ecpb_pkg::PulseW;
  localparam int unsigned TimerW = ecpb_pkg::TimerW;

  ecpb_pkg::phase_e    phase_q, phase_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [PulseW-1:0]   pidx_q, pidx_d;
  logic [TimerW-1:0]   timer_q, timer_d;
  logic                cpu_q, cpu_d;
  logic                drive_q, drive_d;

  logic [TimerW-1:0]   on_load, off_load, timer_dec;
  logic [PulseW-1:0]   pidx_inc;
  logic                target_hit, burst_empty;

  // A zero on or off time behaves as one tick.
  assign on_load    = (cfg_i.on_ticks == '0) ? '0 : cfg_i.on_ticks - TimerW'(1);
  assign off_load   = (cfg_i.off_ticks == '0) ? '0 : cfg_i.off_ticks - TimerW'(1);
  assign timer_dec  = timer_q - TimerW'(1);
  assign pidx_inc   = pidx_q + PulseW'(1);
  assign target_hit = (count_q >= cfg_i.event_target);
  assign burst_empty = (cfg_i.pulse_count == '0);

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    pidx_d  = pidx_q;
    timer_d = timer_q;
    cpu_d   = cpu_q;
    drive_d = drive_q;
    case (phase_q)
      ecpb_pkg::PH_IDLE: begin
        if (target_hit) begin
          count_d = '0;
          pidx_d  = '0;
          if (burst_empty) begin
            drive_d = 1'b0;
          end else begin
            drive_d = 1'b1;
            timer_d = on_load;
            phase_d = ecpb_pkg::PH_ON;
          end
        end else if (!pin_a_i && !pin_b_i) begin
          count_d = count_q + CountW'(1);
          cpu_d   = 1'b1;
          timer_d = cfg_i.debounce_ticks;
          phase_d = ecpb_pkg::PH_WAIT;
        end
      end
      ecpb_pkg::PH_WAIT: begin
        if (timer_q != '0) begin
          timer_d = timer_dec;
        end else if (pin_a_i && pin_b_i) begin
          cpu_d = 1'b0;
          if (target_hit) begin
            count_d = '0;
            pidx_d  = '0;
            if (burst_empty) begin
              drive_d = 1'b0;
              phase_d = ecpb_pkg::PH_IDLE;
            end else begin
              drive_d = 1'b1;
              timer_d = on_load;
              phase_d = ecpb_pkg::PH_ON;
            end
          end else begin
            phase_d = ecpb_pkg::PH_IDLE;
          end
        end
      end
      ecpb_pkg::PH_ON: begin
        if (timer_q != '0) begin
          timer_d = timer_dec;
        end else begin
          drive_d = 1'b0;
          timer_d = off_load;
          phase_d = ecpb_pkg::PH_OFF;
        end
      end
      ecpb_pkg::PH_OFF: begin
        if (timer_q != '0) begin
          timer_d = timer_dec;
        end else if (pidx_inc >= cfg_i.pulse_count || pidx_inc == '0) begin
          pidx_d  = '0;
          drive_d = 1'b0;
          phase_d = ecpb_pkg::PH_IDLE;
        end else begin
          pidx_d  = pidx_inc;
          drive_d = 1'b1;
          timer_d = on_load;
          phase_d = ecpb_pkg::PH_ON;
        end
      end
      default: begin
        phase_d = ecpb_pkg::PH_IDLE;
        drive_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ecpb_pkg::PH_IDLE;
      count_q <= '0;
      pidx_q  <= '0;
      timer_q <= '0;
      cpu_q   <= 1'b0;
      drive_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      pidx_q  <= pidx_d;
      timer_q <= timer_d;
      cpu_q   <= cpu_d;
      drive_q <= drive_d;
    end
  end

  // The result is the state after the tick.
  assign res_o.drive_out     = drive_d;
  assign res_o.led_out       = drive_d;
  assign res_o.cpu_signal    = cpu_d;
  assign res_o.events_so_far = count_d;

endmodule

`default_nettype wire

// ----- rtl/core/encoder_count_pulse_burst.sv -----
// Channel   | Direction | Ports           | Payload (lowest bit first)
// ----------+-----------+-----------------+---------------------------------------------
// s_axis    | in        | tvalid/tready   | tdata[7:0]: pin_a, pin_b, zero pad
// m_axis    | out       | tvalid/tready   | tdata[15:0]: drive_out, led_out, cpu_signal,
//           |           |                 |   events_so_far[7:0], zero pad
// cfg       | in        | we/idx/data     | 0 event_target, 1 pulse_count,
//           |           |                 |   2 debounce_ticks, 3 on_ticks, 4 off_ticks
//
// Each tick moves from its input transaction into the input register, then on
// through the sequencer step into the result register. A new tick is accepted
// every cycle while the result side keeps taking transactions.
// The sequencer state only advances when a tick moves into the result register,
// so a stall on the output holds the tick in the input register and no state is
// lost. Reset returns the sequencer to idle with the count, timer and levels at
// zero and loads the configuration defaults.

`default_nettype none

module encoder_count_pulse_burst (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input ticks.
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // pin_a, pin_b
  // Results.
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [15:0]                   m_axis_tdata,  // drive, led, cpu, events[7:0]
  // Configuration writes.
  input  wire logic                          cfg_we_i,
  input  wire logic [ecpb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ecpb_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned ResW = $bits(ecpb_pkg::res_t);

  ecpb_pkg::cfg_t cfg;
  ecpb_pkg::res_t res_next;

  // Input register.
  logic       in_vld_q;
  logic [1:0] pins_q;

  // Result register.
  logic           out_vld_q;
  ecpb_pkg::res_t res_q;

  logic advance;

  // A held tick moves on when the result slot is empty or being emptied.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      pins_q <= s_axis_tdata[1:0];
    end
  end

  ecpb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ecpb_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .pin_a_i (pins_q[0]),
    .pin_b_i (pins_q[1]),
    .cfg_i   (cfg),
    .res_o   (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(16 - ResW)'(0),
                          res_q.events_so_far,
                          res_q.cpu_signal,
                          res_q.led_out,
                          res_q.drive_out};

endmodule

`default_nettype wire
